// File: design/assert_macros.svh
// Assertion macros shared by the hash map modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/chm_pkg.sv
// Package for the chained hash map: commands, status codes, queue entry type.
`default_nettype none
package chm_pkg;
   localparam int BucketsDefault = 256;
   localparam int EntriesDefault = 1024;
   localparam int CountW = 11;

   typedef enum logic [1:0] {
      CMD_FIND = 2'd0, CMD_SET = 2'd1, CMD_DEL = 2'd2, CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HIT = 3'd0, ST_INSERTED = 3'd1, ST_NOT_FOUND = 3'd2,
      ST_POOL_FULL = 3'd3, ST_CLEARED = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] key;
      logic [31:0] value;
   } cmd_item_type;
endpackage
`default_nettype wire

// File: design/chm_front.sv
// Front end: accepts commands and holds them in a short queue for the engine.
`default_nettype none
`include "assert_macros.svh"
module chm_front
   import chm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire cmd_item_type in_item,
   output logic              q_valid,
   input  wire logic         q_ready,
   output cmd_item_type      q_item
);
   cmd_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         push, pop;

   assign in_ready = (fill_ff != 2'd2);
   assign q_valid  = (fill_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   `CHK_IMPLY(a_fill_range, clock, reset, 1'b1, fill_ff <= 2'd2, "queue fill out of range")
   `CHK_NEXT(a_full_hold, clock, reset, fill_ff == 2'd2 && !pop, fill_ff == 2'd2,
      "full queue lost an entry")
endmodule
`default_nettype wire

// File: design/chm_engine.sv
// Back end: walks bucket chains in the entry pool and updates the table.
`default_nettype none
`include "assert_macros.svh"
module chm_engine
   import chm_pkg::*;
#(
   parameter int BUCKETS = BucketsDefault,
   parameter int ENTRIES = EntriesDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [3:0]   index_bits,
   input  wire logic         q_valid,
   output logic              q_ready,
   input  wire cmd_item_type q_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_value,
   output logic [CountW-1:0] rsp_count
);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int PW = $clog2(ENTRIES + 1);
   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [PW-1:0] NIL = PW'(ENTRIES);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_HEAD   = 9'b000000010,
      S_READ   = 9'b000000100,
      S_CHECK  = 9'b000001000,
      S_ALLOC  = 9'b000010000,
      S_FREERD = 9'b000100000,
      S_UNLINK = 9'b001000000,
      S_CLEAR  = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // bucket heads, with one valid bit per bucket so a clear resets every bucket at once
   logic [PW-1:0] head_mem [BUCKETS];
   logic [BUCKETS-1:0] head_vld_ff;
   logic [31:0]   key_mem  [ENTRIES];
   logic [31:0]   val_mem  [ENTRIES];
   logic [PW-1:0] next_mem [ENTRIES];

   cmd_item_type  cur_cmd_ff;
   logic [BW-1:0] bucket_ff;
   logic [PW-1:0] cur_ff, prev_ff, free_head_ff, mark_ff;
   logic [PW-1:0] head_rd_ff;
   logic          head_rd_vld_ff;
   logic [31:0]   key_rd_ff, val_rd_ff;
   logic [PW-1:0] next_rd_ff, free_next_ff;
   logic [EW:0]   steps_ff;
   logic          ready_ff;
   logic [CountW-1:0] count_ff;
   logic [2:0]    status_ff;
   logic [31:0]   value_ff;
   logic          out_valid_ff;
   logic [2:0]    out_status_ff;
   logic [31:0]   out_value_ff;
   logic [CountW-1:0] out_count_ff;

   logic [3:0]    bits_eff;
   logic [31:0]   mask;
   logic [BW-1:0] bucket_in;
   logic [PW-1:0] head_val;
   logic          walk_live, key_hit, out_load;

   always_comb begin
      bits_eff  = (index_bits == 4'd0) ? 4'd1 : index_bits;
      mask      = (32'd1 << bits_eff) - 32'd1;
      bucket_in = BW'((q_item.key & mask) % BUCKETS);
      head_val  = head_rd_vld_ff ? head_rd_ff : NIL;
      walk_live = (cur_ff < NIL) && (steps_ff < (EW+1)'(ENTRIES));
      key_hit   = walk_live && ready_ff && (key_rd_ff == cur_cmd_ff.key);
      out_load  = (state_ff == S_OUT) && (!out_valid_ff || rsp_ready);
   end

   assign q_ready    = (state_ff == S_IDLE);
   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_count  = out_count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (q_valid) state_in = (q_item.cmd == CMD_CLEAR) ? S_CLEAR : S_HEAD;
         S_HEAD:  state_in = S_READ;
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (key_hit) state_in = (cur_cmd_ff.cmd == CMD_DEL) ? S_UNLINK : S_OUT;
            else if (walk_live) state_in = S_CHECK;
            else if (cur_cmd_ff.cmd != CMD_SET) state_in = S_OUT;
            else if (free_head_ff < NIL) state_in = S_FREERD;
            else if (mark_ff < NIL) state_in = S_ALLOC;
            else state_in = S_OUT;
         end
         S_ALLOC: state_in = S_OUT;
         S_FREERD: state_in = S_ALLOC;
         S_UNLINK: state_in = S_OUT;
         S_CLEAR: state_in = S_OUT;
         S_OUT: if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // the chain walk and the decisions live in one clocked block for clarity
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_vld_ff  <= '0;
         free_head_ff <= NIL;
         mark_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_cmd_ff <= q_item;
                  bucket_ff  <= bucket_in;
               end
            end
            S_HEAD: begin
               // head read registered below; S_READ then loads the chain head into cur_ff
               prev_ff  <= NIL;
               steps_ff <= '0;
               ready_ff <= 1'b0;
            end
            S_READ: begin
               cur_ff <= head_val;
            end
            S_CHECK: begin
               if (key_hit) begin
                  status_ff <= ST_HIT;
                  if (cur_cmd_ff.cmd == CMD_FIND) begin
                     value_ff <= val_rd_ff;
                  end else begin
                     value_ff <= '0;
                  end
                  if (cur_cmd_ff.cmd == CMD_SET) begin
                     val_mem[cur_ff[EW-1:0]] <= cur_cmd_ff.value;
                  end
               end else if (walk_live && ready_ff) begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= next_rd_ff;
                  steps_ff <= steps_ff + 1'b1;
                  ready_ff <= 1'b0;
               end else if (walk_live) begin
                  // wait for the registered entry read
                  ready_ff <= 1'b1;
               end else begin
                  value_ff <= '0;
                  if (cur_cmd_ff.cmd == CMD_SET) begin
                     if (free_head_ff < NIL) begin
                        cur_ff <= free_head_ff;
                     end else if (mark_ff < NIL) begin
                        cur_ff  <= mark_ff;
                        mark_ff <= mark_ff + 1'b1;
                     end else begin
                        status_ff <= ST_POOL_FULL;
                     end
                  end else begin
                     status_ff <= ST_NOT_FOUND;
                  end
               end
            end
            S_FREERD: begin
               free_head_ff <= free_next_ff;
            end
            S_ALLOC: begin
               key_mem[cur_ff[EW-1:0]]  <= cur_cmd_ff.key;
               val_mem[cur_ff[EW-1:0]]  <= cur_cmd_ff.value;
               next_mem[cur_ff[EW-1:0]] <= head_val;
               head_mem[bucket_ff]      <= cur_ff;
               head_vld_ff[bucket_ff]   <= 1'b1;
               count_ff  <= count_ff + 1'b1;
               status_ff <= ST_INSERTED;
            end
            S_UNLINK: begin
               if (prev_ff < NIL) begin
                  next_mem[prev_ff[EW-1:0]] <= next_rd_ff;
               end else begin
                  head_mem[bucket_ff]    <= next_rd_ff;
                  head_vld_ff[bucket_ff] <= 1'b1;
               end
               next_mem[cur_ff[EW-1:0]] <= free_head_ff;
               free_head_ff <= cur_ff;
               if (count_ff != '0) count_ff <= count_ff - 1'b1;
               status_ff <= ST_HIT;
            end
            S_CLEAR: begin
               head_vld_ff  <= '0;
               free_head_ff <= NIL;
               mark_ff      <= '0;
               count_ff     <= '0;
               status_ff    <= ST_CLEARED;
               value_ff     <= '0;
            end
            S_OUT: begin
               // load the output register once the previous result has left
               if (out_load) begin
                  out_status_ff <= status_ff;
                  out_value_ff  <= value_ff;
                  out_count_ff  <= count_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // registered memory reads
   always_ff @(posedge clock) begin
      head_rd_ff     <= head_mem[bucket_ff];
      head_rd_vld_ff <= head_vld_ff[bucket_ff];
      key_rd_ff      <= key_mem[cur_ff[EW-1:0]];
      val_rd_ff      <= val_mem[cur_ff[EW-1:0]];
      next_rd_ff     <= next_mem[cur_ff[EW-1:0]];
      free_next_ff   <= next_mem[free_head_ff[EW-1:0]];
   end

   `CHK_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CountW'(ENTRIES),
      "live count above pool size")
   `CHK_IMPLY(a_accept_idle, clock, reset, q_valid && q_ready,
      !out_valid_ff || state_ff == S_IDLE, "command taken outside idle")
   `CHK_NEXT(a_clear_empty, clock, reset, state_ff == S_CLEAR, count_ff == '0,
      "clear left live entries")
   `CHK_NEXT(a_rsp_hold, clock, reset, out_valid_ff && !rsp_ready, out_valid_ff,
      "result dropped while stalled")
endmodule
`default_nettype wire

// File: design/chained_hash_map_32bit_key.sv
// Top level of the chained hash map with 32-bit keys.
// Usage:
//  Commands enter on req_ (tdata: cmd[1:0], key[33:2], value_in[65:34], zero pad).
//  Results leave on rsp_ (tdata: status[2:0], value_out[34:3], entry_count[45:35]).
//  A transfer happens when tvalid and tready are both high at a rising clock edge.
//  csr_wr_en with csr_wr_data sets index_bits (log2 of buckets in use); write only
//  while idle.
//  A command passes S_HEAD, S_READ and S_CHECK, which walks the chain with one
//  registered read per entry, then S_OUT; an insert adds S_ALLOC, after S_FREERD
//  when a freed slot is reused; a delete adds S_UNLINK; a clear takes S_CLEAR in
//  place of the walk. One command runs at a time, so chain length sets throughput.
//  A two-entry queue in front takes new commands while the engine is busy.
//  Reset (synchronous, active high) empties all chains, the free list and the
//  count and sets index_bits to 8.
//  When the receiver holds rsp_tready low, the result waits in the output
//  register; the engine stalls and the queue fills, then req_tready drops.
`default_nettype none
module chained_hash_map_32bit_key
   import chm_pkg::*;
#(
   parameter int BUCKETS = BucketsDefault,
   parameter int ENTRIES = EntriesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // cmd, key, value_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // status, value_out, entry_count
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data
);
   logic [3:0]        index_bits_ff;
   cmd_item_type      in_item, q_item;
   logic              q_valid, q_ready;
   logic [2:0]        status;
   logic [31:0]       value_out;
   logic [CountW-1:0] count;

   always_ff @(posedge clock) begin
      if (reset) index_bits_ff <= 4'd8;
      else if (csr_wr_en) index_bits_ff <= csr_wr_data;
   end

   always_comb begin
      in_item.cmd   = cmd_type'(req_tdata[1:0]);
      in_item.key   = req_tdata[33:2];
      in_item.value = req_tdata[65:34];
   end

   chm_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   chm_engine #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_engine (
      .clock(clock), .reset(reset), .index_bits(index_bits_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_status(status), .rsp_value(value_out), .rsp_count(count)
   );

   assign rsp_tdata = {2'b00, count, value_out, status};
endmodule
`default_nettype wire

// File: verif/tb_chained_hash_map_32bit_key.sv
// Testbench for the chained hash map: directed and random commands checked against a map model.
`timescale 1ns / 1ps
module tb_chained_hash_map_32bit_key;
   import chm_pkg::*;

   localparam int NB = 256;
   localparam int NE = 1024;
   localparam int WATCH_LIMIT = 40000;

   typedef struct packed {
      status_type  status;
      logic [31:0] value;
      logic [10:0] count;
   } map_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   chained_hash_map_32bit_key dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // map model state
   logic [3:0]  m_bits;
   int unsigned m_head[NB];
   logic [31:0] m_key[NE];
   logic [31:0] m_val[NE];
   int unsigned m_next[NE];
   int unsigned m_free, m_mark, m_live;

   cmd_item_type   pending_cmds[$];
   map_answer_type expected_answers[$];
   int errors = 0;
   int watch = 0;
   bit calm = 1'b0;

   function automatic void map_clear();
      for (int i = 0; i < NB; i++) m_head[i] = NE;
      m_free = NE;
      m_mark = 0;
      m_live = 0;
   endfunction

   function automatic map_answer_type map_apply(cmd_item_type c);
      map_answer_type a;
      int unsigned bits, b, cur, prv, hit, steps, slot;
      bits = (m_bits == 0) ? 1 : m_bits;
      b = (c.key & ((32'd1 << bits) - 1)) % NB;
      a.status = ST_NOT_FOUND;
      a.value = '0;
      if (c.cmd == CMD_CLEAR) begin
         map_clear();
         a.status = ST_CLEARED;
      end else begin
         cur = m_head[b]; prv = NE; hit = NE; steps = 0;
         while (cur < NE && steps < NE) begin
            if (m_key[cur] == c.key) begin
               hit = cur;
               break;
            end
            prv = cur; cur = m_next[cur]; steps++;
         end
         if (hit == NE) prv = NE;
         if (c.cmd == CMD_FIND) begin
            if (hit < NE) begin
               a.status = ST_HIT;
               a.value = m_val[hit];
            end
         end else if (c.cmd == CMD_SET) begin
            if (hit < NE) begin
               m_val[hit] = c.value;
               a.status = ST_HIT;
            end else begin
               slot = NE;
               if (m_free < NE) begin
                  slot = m_free; m_free = m_next[slot];
               end else if (m_mark < NE) begin
                  slot = m_mark; m_mark++;
               end
               if (slot < NE) begin
                  m_key[slot] = c.key; m_val[slot] = c.value;
                  m_next[slot] = m_head[b]; m_head[b] = slot;
                  m_live++;
                  a.status = ST_INSERTED;
               end else a.status = ST_POOL_FULL;
            end
         end else if (hit < NE) begin
            if (prv < NE) m_next[prv] = m_next[hit];
            else m_head[b] = m_next[hit];
            m_next[hit] = m_free; m_free = hit;
            if (m_live > 0) m_live--;
            a.status = ST_HIT;
         end
      end
      a.count = m_live[10:0];
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
               cmd_item_type c;
               c = pending_cmds.pop_front();
               expected_answers.push_back(map_apply(c));
               req_tdata <= {6'd0, c.value, c.key, c.cmd};
               req_tvalid <= 1'b1;
            end else req_tvalid <= 1'b0;
         end
         rsp_tready <= calm || $urandom_range(99) >= 6;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_answers.size() == 0) begin
            $display("unexpected result transfer %0h at %0t", rsp_tdata, $time);
            errors++;
         end else begin
            map_answer_type w;
            w = expected_answers.pop_front();
            if (rsp_tdata[2:0] !== w.status) report_mismatch("status", rsp_tdata[2:0], w.status);
            if (rsp_tdata[34:3] !== w.value) report_mismatch("value", rsp_tdata[34:3], w.value);
            if (rsp_tdata[45:35] !== w.count) report_mismatch("count", rsp_tdata[45:35], w.count);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic cmd_item_type mk(cmd_type c, logic [31:0] k, logic [31:0] v);
      cmd_item_type i;
      i.cmd = c; i.key = k; i.value = v;
      return i;
   endfunction

   task automatic drain();
      while (pending_cmds.size() > 0 || expected_answers.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_bits(logic [3:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      m_bits = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random phase: keys drawn from a small set in a few buckets so chains grow
   task automatic random_phase(int n, int pool);
      logic [31:0] keys[16];
      for (int i = 0; i < 16; i++)
         keys[i] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(pool);
      for (int i = 0; i < n; i++) begin
         int r;
         logic [31:0] k;
         r = $urandom_range(99);
         k = ($urandom_range(9) == 0) ? $urandom : keys[$urandom_range(15)];
         if (r < 30) pending_cmds.push_back(mk(CMD_FIND, k, $urandom));
         else if (r < 70) pending_cmds.push_back(mk(CMD_SET, k, $urandom));
         else if (r < 98) pending_cmds.push_back(mk(CMD_DEL, k, $urandom));
         else pending_cmds.push_back(mk(CMD_CLEAR, $urandom, $urandom));
      end
   endtask

   initial begin
      m_bits = 4'd8;
      map_clear();
      for (int i = 0; i < NE; i++) begin
         m_key[i] = '0; m_val[i] = '0; m_next[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every command, update, chain delete, clear
      pending_cmds.push_back(mk(CMD_FIND, 32'h0, 32'h0));
      pending_cmds.push_back(mk(CMD_DEL, 32'hFFFF_FFFF, 32'h0));
      pending_cmds.push_back(mk(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_cmds.push_back(mk(CMD_SET, 32'h0000_00FF, 32'h1234_5678));
      pending_cmds.push_back(mk(CMD_SET, 32'h0000_0000, 32'h0));
      pending_cmds.push_back(mk(CMD_FIND, 32'hFFFF_FFFF, 32'h0));
      pending_cmds.push_back(mk(CMD_SET, 32'hFFFF_FFFF, 32'hA5A5_5A5A));
      pending_cmds.push_back(mk(CMD_FIND, 32'hFFFF_FFFF, 32'h0));
      pending_cmds.push_back(mk(CMD_FIND, 32'h0000_00FF, 32'h0));
      pending_cmds.push_back(mk(CMD_DEL, 32'h0000_00FF, 32'h0));
      pending_cmds.push_back(mk(CMD_FIND, 32'h0000_00FF, 32'h0));
      pending_cmds.push_back(mk(CMD_DEL, 32'hFFFF_FFFF, 32'h0));
      pending_cmds.push_back(mk(CMD_SET, 32'h0000_01FF, 32'h5));
      pending_cmds.push_back(mk(CMD_FIND, 32'h0000_00FF, 32'h0));
      pending_cmds.push_back(mk(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_cmds.push_back(mk(CMD_FIND, 32'h0000_01FF, 32'h0));
      drain();
      // long chain in one bucket: hit the deepest entry, update, free one, reuse it
      write_bits(4'd0);
      for (int i = 0; i < 150; i++) pending_cmds.push_back(mk(CMD_SET, i * 2, i));
      pending_cmds.push_back(mk(CMD_FIND, 32'd0, 32'h0));
      pending_cmds.push_back(mk(CMD_SET, 32'd2, 32'h77));
      pending_cmds.push_back(mk(CMD_DEL, 32'd100, 32'h0));
      pending_cmds.push_back(mk(CMD_SET, 32'h1357, 32'h7));
      pending_cmds.push_back(mk(CMD_FIND, 32'h1357, 32'h0));
      calm = 1'b1;
      drain();
      calm = 1'b0;
      // index_bits changed with live entries: lookups miss, clear reclaims
      write_bits(4'd15);
      pending_cmds.push_back(mk(CMD_FIND, 32'h1357, 32'h0));
      pending_cmds.push_back(mk(CMD_SET, 32'h1357, 32'h9));
      pending_cmds.push_back(mk(CMD_CLEAR, 32'h0, 32'h0));
      drain();
      random_phase(80, 15);
      drain();
      write_bits(4'd1);
      random_phase(80, 7);
      drain();
      write_bits(4'd4);
      calm = 1'b1;
      random_phase(70, 63);
      drain();
      calm = 1'b0;
      write_bits(4'd8);
      random_phase(80, 1023);
      drain();
      write_bits(4'd9);
      random_phase(70, 511);
      drain();
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

// File: files.f
+incdir+design
design/chm_pkg.sv
design/chm_front.sv
design/chm_engine.sv
design/chained_hash_map_32bit_key.sv
verif/tb_chained_hash_map_32bit_key.sv
